// ===== rtl/core/bqc_pkg.sv =====
// Shared types and constants for the biquad cascade.
// No dependencies.
`default_nettype none
package bqc_pkg;
  localparam int MaxStages = 8;
  localparam int StageW = $clog2(MaxStages + 1);
  localparam int StIdxW = $clog2(MaxStages);
  localparam int CoefDepth = 5 * MaxStages;
  localparam int NumTaps = 5;
  localparam int TapW = 3;
  localparam logic REQ_FILTER = 1'b0;
  localparam logic REQ_LOAD = 1'b1;
  localparam logic CFG_NUM_STAGES = 1'b0;
  localparam logic CFG_POST_SHIFT = 1'b1;

  typedef logic signed [15:0] q15_t;

  typedef struct packed {
    logic       go;
    logic [3:0] sh;
  } stage_ctl_t;

  typedef struct packed {
    logic        valid;
    logic [TapW-1:0] tap;
    q15_t        coef;
  } coef_wr_t;

  function automatic q15_t shift_sat(input logic signed [31:0] acc, input logic [3:0] sh);
    logic signed [31:0] r;
    r = acc >>> (5'd15 - {1'b0, sh});
    if (r > 32'sd32767) return 16'sh7fff;
    else if (r < -32'sd32768) return 16'sh8000;
    else return r[15:0];
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/bqc_cell.sv =====
// One biquad section: its five coefficients, history and a serial MAC.
// Depends on bqc_pkg.
`default_nettype none
module bqc_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bqc_pkg::coef_wr_t cw,
  input  wire bqc_pkg::stage_ctl_t ctl,
  input  wire bqc_pkg::q15_t     x_in,
  output bqc_pkg::q15_t          y_out,
  output logic                   done
);
  import bqc_pkg::*;
  q15_t coef_r [NumTaps];
  q15_t x1_r, x2_r, y1_r, y2_r, x_r;
  logic [31:0] acc_r, acc_nxt;
  logic [TapW-1:0] step_r;
  logic busy_r, done_r;
  logic [3:0] sh_r;
  q15_t opnd, y;
  logic signed [31:0] prod_r;
  logic prodv_r;

  // Products leave the multiplier register in the next cycle; a1, a2 subtract.
  always_comb begin
    case (step_r)
      3'd0: opnd = x_r;
      3'd1: opnd = x1_r;
      3'd2: opnd = x2_r;
      3'd3: opnd = y1_r;
      3'd4: opnd = y2_r;
      default: opnd = '0;
    endcase
    acc_nxt = (step_r >= 3'd4 && prodv_r) ? acc_r - prod_r : acc_r + prod_r;
    y = shift_sat(acc_nxt, sh_r);
  end

  always_ff @(posedge clk) begin
    if (cw.valid) coef_r[cw.tap] <= cw.coef;
    if (!rst_n) begin
      for (int i = 0; i < NumTaps; i++) coef_r[i] <= '0;
      x1_r <= '0; x2_r <= '0; y1_r <= '0; y2_r <= '0;
      busy_r <= 1'b0; done_r <= 1'b0; prodv_r <= 1'b0; step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.go) begin
        busy_r <= 1'b1; step_r <= '0; acc_r <= '0; x_r <= x_in; sh_r <= ctl.sh;
        prodv_r <= 1'b0;
      end else if (busy_r) begin
        if (step_r < 3'(NumTaps))
          prod_r <= coef_r[step_r] * opnd;
        prodv_r <= step_r < 3'(NumTaps);
        if (prodv_r) acc_r <= acc_nxt;
        step_r <= step_r + 3'd1;
        if (step_r == 3'(NumTaps)) begin
          busy_r <= 1'b0; done_r <= 1'b1; y_out <= y;
          x2_r <= x1_r; x1_r <= x_r; y2_r <= y1_r; y1_r <= y;
        end
      end
    end
  end
  assign done = done_r;
endmodule
`default_nettype wire

// ===== rtl/core/biquad_cascade_iir_q15_top.sv =====
// Top level of the biquad cascade: request handling, cell chain, output register.
// Depends on bqc_pkg and bqc_cell.
//
//  channel | ports                              | direction
//  in      | in_valid/in_stall, 5 fields        | request in
//  out     | out_valid/out_stall, 2 fields      | result out
//  cfg     | cfg_we, cfg_index, cfg_data        | register write
//
// A sample passes through each stage in use in turn (serial MAC in each cell)
// from acceptance to out_valid; its last step loads the output register.
// Loads write the addressed coefficient on acceptance. Reset clears history,
// coefficients and post shift and sets the stage count to one. A new request is
// refused while a sample is in flight; a finished sample waits in its cell
// while the previous result is still held by out_stall.
`default_nettype none
module biquad_cascade_iir_q15_top (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic in_req_type,
  input  wire logic signed [15:0] in_sample_in,
  input  wire logic [5:0] in_coef_index,
  input  wire logic signed [15:0] in_coef_value,
  input  wire logic in_last_in,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic signed [15:0] out_sample_out,
  output logic      out_last_out,
  input  wire logic cfg_we,
  input  wire logic cfg_index,
  input  wire logic [3:0] cfg_data
);
  import bqc_pkg::*;
  logic [3:0] nst_r, psh_r;
  logic busy_r, last_r, ov_r, fin_r;
  logic fin;
  logic [StageW-1:0] nuse;
  logic [StIdxW-1:0] last_st;
  logic acc_in;
  q15_t chain [MaxStages+1];
  logic dn [MaxStages];
  q15_t y_sel;
  logic [9:0] cmul;
  logic [3:0] cstage;
  logic [TapW-1:0] ctap;

  always_comb begin
    if (nst_r == 4'd0) nuse = StageW'(1);
    else if (nst_r > 4'(MaxStages)) nuse = StageW'(MaxStages);
    else nuse = StageW'(nst_r);
    last_st = StIdxW'(nuse - StageW'(1));
  end

  // Slot number split into stage and tap; 13/64 is close enough to 1/5 for
  // every 6-bit slot number.
  always_comb begin
    cmul = 10'(in_coef_index) * 10'd13;
    cstage = cmul[9:6];
    ctap = TapW'(in_coef_index - 6'({2'b00, cstage} * 6'd5));
  end

  assign in_stall = busy_r;
  assign acc_in = in_valid && !in_stall;
  assign chain[0] = in_sample_in;

  for (genvar s = 0; s < MaxStages; s++) begin : g_cell
    coef_wr_t cw;
    stage_ctl_t ctl;
    logic go;
    if (s == 0) begin : g_first
      assign go = acc_in && in_req_type == REQ_FILTER;
    end else begin : g_next
      assign go = dn[s-1] && StageW'(s) < nuse;
    end
    assign cw = '{valid: acc_in && in_req_type == REQ_LOAD
                         && in_coef_index < 6'(CoefDepth) && cstage == 4'(s),
                  tap: ctap, coef: in_coef_value};
    assign ctl = '{go: go, sh: psh_r};
    bqc_cell u_cell (.clk, .rst_n, .cw, .ctl, .x_in(chain[s]), .y_out(chain[s+1]),
                     .done(dn[s]));
  end

  always_comb begin
    y_sel = chain[1];
    for (int s = 0; s < MaxStages; s++)
      if (StageW'(s + 1) == nuse) y_sel = chain[s+1];
  end

  // The last cell holds its output until the output register is free.
  assign fin = busy_r && (fin_r || dn[last_st]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nst_r <= 4'd1; psh_r <= '0; busy_r <= 1'b0; ov_r <= 1'b0; fin_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_NUM_STAGES) nst_r <= cfg_data;
        else psh_r <= cfg_data;
      end
      if (acc_in && in_req_type == REQ_FILTER) begin
        busy_r <= 1'b1; last_r <= in_last_in;
      end
      if (fin && (!ov_r || !out_stall)) begin
        busy_r <= 1'b0; fin_r <= 1'b0; ov_r <= 1'b1;
        out_sample_out <= y_sel; out_last_out <= last_r;
      end else begin
        if (fin) fin_r <= 1'b1;
        if (ov_r && !out_stall) ov_r <= 1'b0;
      end
    end
  end
  assign out_valid = ov_r;
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the biquad cascade: drives requests, predicts each result.
// Depends on bqc_pkg and biquad_cascade_iir_q15_top.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bqc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_req_type = REQ_FILTER;
  logic signed [15:0] in_sample_in = '0;
  logic [5:0] in_coef_index = '0;
  logic signed [15:0] in_coef_value = '0;
  logic in_last_in = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_sample_out;
  logic out_last_out;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_NUM_STAGES;
  logic [3:0] cfg_data = '0;

  biquad_cascade_iir_q15_top DUT (.*);

  always #5 clk = ~clk;

  typedef struct {
    q15_t sample;
    logic last;
  } filt_result_t;

  q15_t coefs [CoefDepth];
  q15_t hist [4*MaxStages];
  logic [3:0] stage_reg;
  logic [3:0] shift_reg;
  filt_result_t pending_results[$];
  int errors = 0;
  int n_results = 0;
  int n_loads = 0;
  int n_samples = 0;
  bit idle_on = 1'b1;
  bit long_hold = 1'b0;
  longint cycles = 0;

  function automatic q15_t shift_saturate(logic [31:0] acc, int unsigned sh);
    longint s;
    s = longint'($signed(acc)) >>> sh;
    if (s > 32767) return 16'sh7fff;
    if (s < -32768) return 16'sh8000;
    return q15_t'(s[15:0]);
  endfunction

  // Apply one accepted request to the predictor.
  task automatic predict_request(logic rt, q15_t smp, logic [5:0] idx, q15_t cv, logic lst);
    int n;
    int unsigned sh;
    q15_t x, y;
    logic [31:0] acc;
    filt_result_t r;
    if (rt == REQ_LOAD) begin
      if (idx < CoefDepth) coefs[idx] = cv;
      n_loads++;
      return;
    end
    n = stage_reg;
    if (n == 0) n = 1;
    if (n > MaxStages) n = MaxStages;
    sh = 15 - shift_reg;
    x = smp;
    for (int st = 0; st < n; st++) begin
      acc = 32'(int'(coefs[st*5]) * int'(x));
      acc += 32'(int'(coefs[st*5+1]) * int'(hist[st*4]));
      acc += 32'(int'(coefs[st*5+2]) * int'(hist[st*4+1]));
      acc -= 32'(int'(coefs[st*5+3]) * int'(hist[st*4+2]));
      acc -= 32'(int'(coefs[st*5+4]) * int'(hist[st*4+3]));
      y = shift_saturate(acc, sh);
      hist[st*4+1] = hist[st*4];
      hist[st*4] = x;
      hist[st*4+3] = hist[st*4+2];
      hist[st*4+2] = y;
      x = y;
    end
    r.sample = x;
    r.last = lst;
    pending_results.push_back(r);
    n_samples++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result checker: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    filt_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: sample_out %0d", out_sample_out);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_sample_out !== e.sample) begin
          $error("sample_out: expected %0d, got %0d", e.sample, out_sample_out);
          errors++;
        end
        if (out_last_out !== e.last) begin
          $error("last_out: expected %0b, got %0b", e.last, out_last_out);
          errors++;
        end
      end
    end
  end

  // Receiver hold-off: random bursts, plus one long stretch on request.
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        for (hold = 0; hold < 300; hold++) @(posedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Valid stays high between requests sent back to back; idling or drain drops it.
  task automatic send_request(logic rt, q15_t smp, logic [5:0] idx, q15_t cv, logic lst);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rt;
    in_sample_in <= smp;
    in_coef_index <= idx;
    in_coef_value <= cv;
    in_last_in <= lst;
    do @(posedge clk); while (in_stall);
    predict_request(rt, smp, idx, cv, lst);
  endtask

  task automatic send_sample(q15_t smp);
    send_request(REQ_FILTER, smp, 6'($urandom), 16'($urandom), 1'($urandom));
  endtask

  task automatic load_coef(logic [5:0] idx, q15_t cv);
    send_request(REQ_LOAD, 16'($urandom), idx, cv, 1'($urandom));
  endtask

  // Waits for every predicted result, then lets a trailing load finish.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [3:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_NUM_STAGES) stage_reg = val;
    else shift_reg = val;
  endtask

  task automatic set_config(logic [3:0] stages, logic [3:0] shift);
    drain();
    write_reg(CFG_NUM_STAGES, stages);
    write_reg(CFG_POST_SHIFT, shift);
    cfg_we <= 1'b0;
  endtask

  task automatic random_coefs(int stages, bit gentle);
    for (int i = 0; i < stages*5; i++)
      load_coef(6'(i), gentle ? q15_t'($urandom_range(0, 16383) - 8192) : 16'($urandom));
  endtask

  // All-zero coefficients after reset give silence, whatever the input.
  task automatic test_reset_state;
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
  endtask

  // Extreme samples and coefficients force wrap-around and saturation.
  task automatic test_extremes;
    set_config(4'd0, 4'd15);
    load_coef(6'd0, 16'sh8000);
    load_coef(6'd1, 16'sh7fff);
    load_coef(6'd2, 16'sh8000);
    load_coef(6'd3, 16'sh7fff);
    load_coef(6'd4, 16'sh8000);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
  endtask

  // Out-of-range slots are ignored; stage counts above the maximum saturate.
  task automatic test_slots_and_stages;
    load_coef(6'd40, 16'sh7fff);
    load_coef(6'd63, 16'sh7fff);
    set_config(4'd15, 4'd0);
    random_coefs(MaxStages, 1'b1);
    send_sample(16'sd12345);
    send_sample(-16'sd20000);
    set_config(4'd8, 4'd7);
    send_sample(16'sd100);
  endtask

  task automatic test_random_phases;
    logic [3:0] st;
    for (int ph = 0; ph < 10; ph++) begin
      st = (ph % 3 == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 3));
      set_config(st, 4'($urandom_range(0, 15)));
      random_coefs(st == 0 ? 1 : (st > 8 ? 8 : st), ph[0]);
      for (int i = 0; i < 20; i++) begin
        if ($urandom_range(0, 9) == 0) load_coef(6'($urandom), 16'($urandom));
        else send_sample(16'($urandom));
      end
    end
  endtask

  // The receiver stops for a long stretch while requests keep coming.
  task automatic test_back_pressure;
    set_config(4'd1, 4'd3);
    long_hold = 1'b1;
    for (int i = 0; i < 12; i++) send_sample(16'($urandom));
  endtask

  task automatic test_no_idle;
    set_config(4'd2, 4'd14);
    idle_on = 1'b0;
    for (int i = 0; i < 40; i++) send_sample(16'($urandom));
  endtask

  initial begin
    foreach (coefs[i]) coefs[i] = '0;
    foreach (hist[i]) hist[i] = '0;
    stage_reg = 4'd1;
    shift_reg = 4'd0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_extremes();
    test_slots_and_stages();
    test_random_phases();
    test_back_pressure();
    test_no_idle();
    drain();
    $display("Covered %0d samples and %0d coefficient loads; %0d results checked.",
             n_samples, n_loads, n_results);
    $display("Stage counts from zero to above the maximum and assorted post shifts were used.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
